// ===== sv/dtep_pkg.sv =====
// Package with constants, types and helper functions of the direction to pixel unit.
`timescale 1ns / 1ps
package dtep_pkg;
    localparam int MAX_WIDTH_DEF     = 8192;
    localparam int COMP_BITS_DEF     = 16;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int CW                = 50;
    localparam int AW                = 24;
    localparam int MW                = 17;
    localparam logic [13:0] WIDTH_RESET = 14'd4096;
    localparam logic [15:0] DEG90  = 16'd11520;
    localparam logic [15:0] DEG180 = 16'd23040;
    localparam logic [15:0] DEG360 = 16'd46080;
    localparam logic [AW-1:0] ANG_MAX = AW'(2949120);
    localparam logic [1:0] ADDR_WIDTH = 2'd0;

    typedef struct packed {
        logic              zero;
        logic              xneg;
        logic              zneg;
        logic              yneg;
        logic              ypos;
        logic [14:0]       width;
    } side_t;

    function automatic logic [AW-1:0] atan_entry(input int i);
        logic [AW-1:0] tab [32];
        tab = '{AW'(1474560), AW'(870484), AW'(459940), AW'(233473), AW'(117189),
                AW'(58653), AW'(29333), AW'(14667), AW'(7334), AW'(3667), AW'(1833),
                AW'(917), AW'(458), AW'(229), AW'(115), AW'(57), AW'(29), AW'(14),
                AW'(7), AW'(4), AW'(2), AW'(1), '0, '0, '0, '0, '0, '0, '0, '0, '0, '0};
        return tab[i];
    endfunction

    function automatic logic [15:0] round_angle(input logic signed [AW:0] a);
        logic [AW-1:0] c;
        logic [AW-1:0] t;
        c = a[AW] ? '0 : (a[AW-1:0] > ANG_MAX ? ANG_MAX : a[AW-1:0]);
        t = (c + AW'(128)) >> 8;
        return (t > AW'(DEG90)) ? DEG90 : t[15:0];
    endfunction
endpackage

// ===== sv/dtep_sqrt_cell.sv =====
// One digit cell of the pipelined square root of x*x + z*z.
`timescale 1ns / 1ps
module dtep_sqrt_cell
    import dtep_pkg::*;
#(
    parameter int LEVEL = 0
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic [33:0] rem_in,
    input  logic [33:0] root_in,
    output logic [33:0] rem_out,
    output logic [33:0] root_out
);
    localparam logic [33:0] BIT = 34'd1 << (2 * LEVEL);
    logic [33:0] trial;
    logic [33:0] rem_next;
    logic [33:0] root_next;
    logic [33:0] rem_reg;
    logic [33:0] root_reg;

    always_comb
    begin
        trial = root_in + BIT;
        if (rem_in >= trial)
        begin
            rem_next  = rem_in - trial;
            root_next = (root_in >> 1) + BIT;
        end
        else
        begin
            rem_next  = rem_in;
            root_next = root_in >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;
endmodule

// ===== sv/dtep_cordic_cell.sv =====
// One vectoring rotation cell of the CORDIC chain.
`timescale 1ns / 1ps
module dtep_cordic_cell
    import dtep_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic signed [CW-1:0] xa_in,
    input  logic signed [CW-1:0] yb_in,
    input  logic signed [AW:0]   ang_in,
    output logic signed [CW-1:0] xa_out,
    output logic signed [CW-1:0] yb_out,
    output logic signed [AW:0]   ang_out
);
    logic signed [CW-1:0] xa_next, yb_next, xa_reg, yb_reg;
    logic signed [AW:0] ang_next, ang_reg, step;

    always_comb
    begin
        step = $signed({1'b0, atan_entry(STAGE)});
        if (yb_in > 0)
        begin
            xa_next  = xa_in + (yb_in >>> STAGE);
            yb_next  = yb_in - (xa_in >>> STAGE);
            ang_next = ang_in + step;
        end
        else
        begin
            xa_next  = xa_in - (yb_in >>> STAGE);
            yb_next  = yb_in + (xa_in >>> STAGE);
            ang_next = ang_in - step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xa_reg  <= '0;
            yb_reg  <= '0;
            ang_reg <= '0;
        end
        else if (en)
        begin
            xa_reg  <= xa_next;
            yb_reg  <= yb_next;
            ang_reg <= ang_next;
        end
    end

    assign xa_out  = xa_reg;
    assign yb_out  = yb_reg;
    assign ang_out = ang_reg;
endmodule

// ===== sv/direction_to_equirect_pixel_unit.sv =====
// Top level of the direction to equirectangular pixel unit.
`timescale 1ns / 1ps
// Fully pipelined: a new transaction may enter every clock cycle while the output is not
// stalled. The stages are 17 square root cells, with the longitude CORDIC cells running
// beside them, then CORDIC_STAGES cells (at most 32) for latitude, then quadrant mapping
// and the pixel products, the reciprocal division and its correction into the output
// register. All stages advance together whenever the output is not stalled, so a stalled
// result stalls the input in that cycle.
// A width register write whose low 14 bits exceed MAX_WIDTH saturates to MAX_WIDTH.
module direction_to_equirect_pixel_unit
    import dtep_pkg::*;
#(
    parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] dir_x,
    input  logic [15:0] dir_y,
    input  logic [15:0] dir_z,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [14:0] lat_angle,
    output logic [15:0] lon_angle,
    output logic [11:0] pixel_row,
    output logic [12:0] pixel_col,
    output logic        row_ok,
    output logic        col_ok,
    output logic        zero_dir
);
    localparam int PRE   = 46 - COMP_BITS_DEF;
    localparam int SQ    = MW;
    localparam int NC    = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    localparam int EA    = SQ + NC;
    localparam int DEPTH = EA + 3;
    localparam logic [16:0] RECIP = 17'd93206;

    logic [14:0] width_reg;
    logic [13:0] wv;
    logic        adv;

    assign pready = 1'b1;
    assign wv     = pwdata[13:0];
    assign prdata = {17'd0, width_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            width_reg <= 15'(WIDTH_RESET);
        else if (psel && penable && pwrite && paddr == ADDR_WIDTH)
            width_reg <= (32'(wv) > 32'(MAX_WIDTH)) ? 15'(MAX_WIDTH) : 15'(wv);
    end

    // Global pipeline enable; every stage moves when the output side is free.
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    logic [DEPTH:1] vld_reg;
    side_t          side_in;
    side_t          side_reg [1:EA+2];
    logic [15:0]    ny_in;
    logic [15:0]    ny_reg   [1:SQ];

    logic signed [15:0] sx, sy, sz;
    logic [15:0] ax, az;
    assign sx = $signed(dir_x);
    assign sy = $signed(dir_y);
    assign sz = $signed(dir_z);
    assign ax = sx[15] ? 16'(-sx) : dir_x;
    assign az = sz[15] ? 16'(-sz) : dir_z;

    // Square root chain and longitude CORDIC chain.
    logic [33:0] rem_w  [SQ+1];
    logic [33:0] root_w [SQ+1];
    logic signed [CW-1:0] lx [NC+1], ly [NC+1];
    logic signed [AW:0]   la [NC+1];
    logic [15:0] lon_t;
    logic [15:0] lon_t_reg [1:SQ];

    assign rem_w[0]  = 34'(32'(ax) * 32'(ax)) + 34'(32'(az) * 32'(az));
    assign root_w[0] = '0;
    assign lx[0] = $signed(CW'(az) << PRE);
    assign ly[0] = $signed(CW'(ax) << PRE);
    assign la[0] = '0;

    genvar g;
    generate
        for (g = 0; g < SQ; g++)
        begin : g_sq
            dtep_sqrt_cell #(.LEVEL(SQ - 1 - g)) u_cell (
                .clk(clk), .rst_n(rst_n), .en(adv), .rem_in(rem_w[g]), .root_in(root_w[g]),
                .rem_out(rem_w[g+1]), .root_out(root_w[g+1]));
        end
        for (g = 0; g < NC; g++)
        begin : g_lon
            dtep_cordic_cell #(.STAGE(g)) u_cell (
                .clk(clk), .rst_n(rst_n), .en(adv), .xa_in(lx[g]), .yb_in(ly[g]),
                .ang_in(la[g]), .xa_out(lx[g+1]), .yb_out(ly[g+1]), .ang_out(la[g+1]));
        end
    endgenerate

    assign lon_t = round_angle(la[NC]);

    // Latitude CORDIC chain.
    logic signed [CW-1:0] tx [NC+1], ty [NC+1];
    logic signed [AW:0]   ta [NC+1];

    assign tx[0] = $signed(CW'(ny_reg[SQ]) << PRE);
    assign ty[0] = $signed(CW'(root_w[SQ]) << PRE);
    assign ta[0] = '0;

    generate
        for (g = 0; g < NC; g++)
        begin : g_lat
            dtep_cordic_cell #(.STAGE(g)) u_cell (
                .clk(clk), .rst_n(rst_n), .en(adv), .xa_in(tx[g]), .yb_in(ty[g]),
                .ang_in(ta[g]), .xa_out(tx[g+1]), .yb_out(ty[g+1]), .ang_out(ta[g+1]));
        end
    endgenerate

    always_comb
    begin
        ny_in         = sy[15] ? 16'(-sy) : dir_y;
        side_in.zero  = (dir_x == 16'd0) && (dir_y == 16'd0) && (dir_z == 16'd0);
        side_in.xneg  = sx[15];
        side_in.zneg  = sz[15];
        side_in.yneg  = sy[15];
        side_in.ypos  = !sy[15] && dir_y != 16'd0;
        side_in.width = width_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[1]  <= side_in;
            ny_reg[1]    <= ny_in;
            lon_t_reg[1] <= lon_t;
            for (int i = 2; i <= EA + 2; i++)
                side_reg[i] <= side_reg[i-1];
            for (int i = 2; i <= SQ; i++)
            begin
                ny_reg[i]    <= ny_reg[i-1];
                lon_t_reg[i] <= lon_t_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[DEPTH-1:1], in_valid};
    end

    // Stage A: quadrant mapping, after the latitude chain.
    side_t sa;
    logic [15:0] tlat, tlon, lat_a, lon_a;
    assign sa   = side_reg[EA];
    assign tlat = round_angle(ta[NC]);
    assign tlon = lon_t_reg[SQ];

    always_comb
    begin
        if (!sa.xneg)
            lon_a = sa.zneg ? DEG180 - tlon : tlon;
        else
            lon_a = sa.zneg ? DEG180 + tlon : DEG360 - tlon;
        lat_a = sa.ypos ? DEG180 - tlat : tlat;
        if (sa.zero)
        begin
            lon_a = '0;
            lat_a = '0;
        end
    end

    logic [15:0] lat_b_reg, lon_b_reg;
    logic [31:0] prow_b_reg, pcol_b_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lat_b_reg  <= lat_a;
            lon_b_reg  <= lon_a;
            prow_b_reg <= 32'(lat_a) * 32'(sa.width >> 1);
            pcol_b_reg <= 32'(lon_a) * 32'(sa.width);
        end
    end

    // Stage B: n / 46080 estimated by a reciprocal multiply that never overshoots.
    logic [33:0] nrow, ncol;
    logic [66:0] pr, pc;
    assign nrow = {1'b0, prow_b_reg, 1'b0} - 34'(DEG180);
    assign ncol = {1'b0, pcol_b_reg, 1'b0} - 34'(DEG360);
    assign pr   = 67'(nrow[32:0]) * 67'(RECIP);
    assign pc   = 67'(ncol[32:0]) * 67'(RECIP);

    logic [15:0] lat_c_reg, lon_c_reg;
    logic [33:0] nrow_c_reg, ncol_c_reg;
    logic [16:0] qr0_c_reg, qc0_c_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lat_c_reg  <= lat_b_reg;
            lon_c_reg  <= lon_b_reg;
            nrow_c_reg <= nrow;
            ncol_c_reg <= ncol;
            qr0_c_reg  <= pr[48:32];
            qc0_c_reg  <= pc[48:32];
        end
    end

    // Stage C: the estimate is at most one short, so one correction step finishes it.
    side_t sc;
    logic [33:0] qr, qc;
    logic [14:0] h;
    logic rok, cok;
    assign sc = side_reg[EA+2];
    assign h  = sc.width >> 1;
    always_comb
    begin
        qr = nrow_c_reg[33] ? 34'd0 : 34'(qr0_c_reg);
        if (!nrow_c_reg[33] && nrow_c_reg >= (qr + 34'd1) * 34'(DEG360))
            qr = qr + 34'd1;
        qc = ncol_c_reg[33] ? 34'd0 : 34'(qc0_c_reg >> 1);
        if (!ncol_c_reg[33] && ncol_c_reg >= (qc + 34'd1) * 34'(2 * DEG360))
            qc = qc + 34'd1;
        rok = !sc.zero && h != '0 && qr < 34'(h);
        cok = !sc.zero && sc.width != '0 && qc < 34'(sc.width);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lat_angle <= lat_c_reg[14:0];
            lon_angle <= lon_c_reg;
            pixel_row <= rok ? qr[11:0] : 12'd0;
            pixel_col <= cok ? qc[12:0] : 13'd0;
            row_ok    <= rok;
            col_ok    <= cok;
            zero_dir  <= sc.zero;
        end
    end
    assign out_valid = vld_reg[DEPTH];
endmodule
